FILE: rtl/core/rtfb_pkg.sv
// shared types and constants for the rgb to framebuffer pixel pipeline
package rtfb_pkg;

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_RED = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE = 2;

  localparam logic [3:0] LEN_MAX = 4'd8;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam logic [31:0] MASK16 = 32'h0000_ffff;
  localparam logic [31:0] MASK24 = 32'h00ff_ffff;
  localparam logic [31:0] MASK32 = 32'hffff_ffff;

  // floor(x / 255) == (x * 32897) >> 23 for any 16-bit x
  localparam logic [16:0] DIV255_RECIP = 17'd32897;
  localparam int unsigned DIV255_SHIFT = 23;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_MODE   = 3'd0,
    CFG_RED_LENGTH   = 3'd1,
    CFG_GREEN_LENGTH = 3'd2,
    CFG_BLUE_LENGTH  = 3'd3,
    CFG_RED_OFFSET   = 3'd4,
    CFG_GREEN_OFFSET = 3'd5,
    CFG_BLUE_OFFSET  = 3'd6,
    CFG_MODE_FLAGS   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DEPTH_15 = 2'd0,
    DEPTH_16 = 2'd1,
    DEPTH_24 = 2'd2,
    DEPTH_32 = 2'd3
  } depth_e;

  localparam int unsigned FLAG_BLEND = 0;
  localparam int unsigned FLAG_DIRECT = 1;

  // decoded configuration seen by the datapath
  typedef struct packed {
    logic [31:0]              depth_mask;
    logic                     blend_en;
    logic                     dither_en;
    logic [NUM_CH-1:0][3:0]   len;
    logic [NUM_CH-1:0][4:0]   off;
  } cfg_t;

  typedef struct packed {
    logic [NUM_CH-1:0][7:0] src;
    logic [NUM_CH-1:0][7:0] dst;
    logic [7:0]             alpha;
    logic [1:0]             dither;
    logic                   last;
  } unpack_t;

  typedef struct packed {
    logic [NUM_CH-1:0][7:0] chan;
    logic [1:0]             dither;
    logic                   last;
  } blend_t;

endpackage

FILE: rtl/core/rtfb_cfg_regs.sv
// configuration registers and decode of effective lengths and masks
module rtfb_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rtfb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rtfb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output rtfb_pkg::cfg_t                   cfg_o
);

  logic [1:0] depth_q;
  logic [3:0] red_len_q, green_len_q, blue_len_q;
  logic [4:0] red_off_q, green_off_q, blue_off_q;
  logic [1:0] flags_q;

  logic [3:0] r_len, g_len, b_len, min_len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= rtfb_pkg::DEPTH_16;
      red_len_q   <= 4'd5;
      green_len_q <= 4'd6;
      blue_len_q  <= 4'd5;
      red_off_q   <= 5'd11;
      green_off_q <= 5'd5;
      blue_off_q  <= 5'd0;
      flags_q     <= 2'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rtfb_pkg::cfg_idx_e'(cfg_index_i))
        rtfb_pkg::CFG_DEPTH_MODE:   depth_q     <= cfg_data_i[1:0];
        rtfb_pkg::CFG_RED_LENGTH:   red_len_q   <= cfg_data_i[3:0];
        rtfb_pkg::CFG_GREEN_LENGTH: green_len_q <= cfg_data_i[3:0];
        rtfb_pkg::CFG_BLUE_LENGTH:  blue_len_q  <= cfg_data_i[3:0];
        rtfb_pkg::CFG_RED_OFFSET:   red_off_q   <= cfg_data_i[4:0];
        rtfb_pkg::CFG_GREEN_OFFSET: green_off_q <= cfg_data_i[4:0];
        rtfb_pkg::CFG_BLUE_OFFSET:  blue_off_q  <= cfg_data_i[4:0];
        rtfb_pkg::CFG_MODE_FLAGS:   flags_q     <= cfg_data_i[1:0];
      endcase
    end
  end

  // lengths above eight saturate
  assign r_len = (red_len_q > rtfb_pkg::LEN_MAX) ? rtfb_pkg::LEN_MAX : red_len_q;
  assign g_len = (green_len_q > rtfb_pkg::LEN_MAX) ? rtfb_pkg::LEN_MAX : green_len_q;
  assign b_len = (blue_len_q > rtfb_pkg::LEN_MAX) ? rtfb_pkg::LEN_MAX : blue_len_q;

  always_comb begin
    min_len = r_len;
    if (g_len < min_len) min_len = g_len;
    if (b_len < min_len) min_len = b_len;
  end

  always_comb begin
    cfg_o = '0;
    unique case (rtfb_pkg::depth_e'(depth_q))
      rtfb_pkg::DEPTH_15, rtfb_pkg::DEPTH_16: cfg_o.depth_mask = rtfb_pkg::MASK16;
      rtfb_pkg::DEPTH_24:                     cfg_o.depth_mask = rtfb_pkg::MASK24;
      rtfb_pkg::DEPTH_32:                     cfg_o.depth_mask = rtfb_pkg::MASK32;
    endcase
    cfg_o.dither_en = (depth_q == rtfb_pkg::DEPTH_15) || (depth_q == rtfb_pkg::DEPTH_16);
    cfg_o.blend_en  = flags_q[rtfb_pkg::FLAG_BLEND];
    if (flags_q[rtfb_pkg::FLAG_DIRECT]) begin
      cfg_o.len[rtfb_pkg::CH_RED]   = min_len;
      cfg_o.len[rtfb_pkg::CH_GREEN] = min_len;
      cfg_o.len[rtfb_pkg::CH_BLUE]  = min_len;
    end else begin
      cfg_o.len[rtfb_pkg::CH_RED]   = r_len;
      cfg_o.len[rtfb_pkg::CH_GREEN] = g_len;
      cfg_o.len[rtfb_pkg::CH_BLUE]  = b_len;
    end
    cfg_o.off[rtfb_pkg::CH_RED]   = red_off_q;
    cfg_o.off[rtfb_pkg::CH_GREEN] = green_off_q;
    cfg_o.off[rtfb_pkg::CH_BLUE]  = blue_off_q;
  end

endmodule

FILE: rtl/core/rtfb_unpack.sv
// stage one: destination unpack, alpha select and dither value
module rtfb_unpack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic [7:0]           alpha_i,
  input  logic [31:0]          dest_pixel_i,
  input  logic                 row_odd_i,
  input  logic                 column_odd_i,
  input  logic                 row_end_i,
  input  rtfb_pkg::cfg_t       cfg_i,
  output logic                 valid_o,
  output rtfb_pkg::unpack_t    data_o
);

  logic              valid_q;
  rtfb_pkg::unpack_t data_d, data_q;
  logic [31:0]       dest_masked;

  assign dest_masked = dest_pixel_i & cfg_i.depth_mask;

  for (genvar c = 0; c < rtfb_pkg::NUM_CH; c++) begin : g_chan
    logic [31:0] shifted;
    logic [7:0]  len_mask;
    logic [7:0]  field;
    logic [15:0] aligned;

    assign shifted  = dest_masked >> cfg_i.off[c];
    assign len_mask = 8'((9'd1 << cfg_i.len[c]) - 9'd1);
    assign field    = shifted[7:0] & len_mask;
    assign aligned  = {8'h00, field} << (rtfb_pkg::LEN_MAX - cfg_i.len[c]);

    // blending off: dst weighted by zero, src by 255, which divides back to src
    assign data_d.dst[c] = cfg_i.blend_en ? aligned[7:0] : 8'h00;
  end

  assign data_d.src[rtfb_pkg::CH_RED]   = red_i;
  assign data_d.src[rtfb_pkg::CH_GREEN] = green_i;
  assign data_d.src[rtfb_pkg::CH_BLUE]  = blue_i;
  assign data_d.alpha  = cfg_i.blend_en ? alpha_i : rtfb_pkg::ALPHA_OPAQUE;
  assign data_d.dither = (row_odd_i ? 2'd1 : 2'd3) ^ (column_odd_i ? 2'd3 : 2'd0);
  assign data_d.last   = row_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/rtfb_blend.sv
// stages two and three: weighted sum, then divide by 255 via reciprocal
module rtfb_blend (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rtfb_pkg::unpack_t    data_i,
  output logic                 valid_o,
  output rtfb_pkg::blend_t     data_o
);

  logic                                valid_sum_q, valid_div_q;
  logic [rtfb_pkg::NUM_CH-1:0][15:0]   sum_d, sum_q;
  logic [1:0]                          dither_q;
  logic                                last_q;
  rtfb_pkg::blend_t                    div_d, div_q;
  logic [7:0]                          inv_alpha;

  assign inv_alpha = rtfb_pkg::ALPHA_OPAQUE - data_i.alpha;

  for (genvar c = 0; c < rtfb_pkg::NUM_CH; c++) begin : g_chan
    logic [32:0] prod;

    assign sum_d[c] = 16'(data_i.dst[c]) * 16'(inv_alpha)
                    + 16'(data_i.src[c]) * 16'(data_i.alpha);
    assign prod     = 33'(sum_q[c]) * 33'(rtfb_pkg::DIV255_RECIP);
    assign div_d.chan[c] = prod[rtfb_pkg::DIV255_SHIFT +: 8];
  end

  assign div_d.dither = dither_q;
  assign div_d.last   = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_sum_q <= 1'b0;
      valid_div_q <= 1'b0;
    end else if (en_i) begin
      valid_sum_q <= valid_i;
      valid_div_q <= valid_sum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q    <= sum_d;
      dither_q <= data_i.dither;
      last_q   <= data_i.last;
      div_q    <= div_d;
    end
  end

  assign valid_o = valid_div_q;
  assign data_o  = div_q;

endmodule

FILE: rtl/core/rtfb_pack.sv
// stage four: dither with saturation, truncate and pack into the output register
module rtfb_pack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rtfb_pkg::blend_t     data_i,
  input  rtfb_pkg::cfg_t       cfg_i,
  output logic                 valid_o,
  output logic [31:0]          pixel_o,
  output logic                 last_o
);

  logic        valid_q;
  logic [31:0] pixel_d, pixel_q;
  logic        last_q;
  logic [rtfb_pkg::NUM_CH-1:0][31:0] placed;

  for (genvar c = 0; c < rtfb_pkg::NUM_CH; c++) begin : g_chan
    logic [2:0] add;
    logic [8:0] sum;
    logic [7:0] sat;
    logic [7:0] trunc;

    // red and blue gain 2d+1, green gains d
    if (c == rtfb_pkg::CH_GREEN) begin : g_green
      assign add = {1'b0, data_i.dither};
    end else begin : g_rb
      assign add = {data_i.dither, 1'b1};
    end

    assign sum   = 9'(data_i.chan[c]) + (cfg_i.dither_en ? 9'(add) : 9'd0);
    assign sat   = sum[8] ? 8'hff : sum[7:0];
    assign trunc = sat >> (rtfb_pkg::LEN_MAX - cfg_i.len[c]);
    assign placed[c] = 32'(trunc) << cfg_i.off[c];
  end

  assign pixel_d = (placed[rtfb_pkg::CH_RED] | placed[rtfb_pkg::CH_GREEN]
                  | placed[rtfb_pkg::CH_BLUE]) & cfg_i.depth_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_q <= pixel_d;
      last_q  <= data_i.last;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;
  assign last_o  = last_q;

endmodule

FILE: rtl/core/rgb_to_framebuffer_pixel.sv
// top level of the rgb to framebuffer pixel pipeline
//
// Converts one RGBA pixel plus the current framebuffer word into a packed
// framebuffer pixel: optional alpha blend, 2x2 ordered dither below 24 bpp,
// truncation to the field lengths and packing at the field offsets.
// Input channel: in_valid_i / in_stall_o with the source components, the
// destination word and the row/column parity and row-end flags.
// Output channel: out_valid_o / out_stall_i with pixel_value_o and
// last_in_row_o. A transfer happens when valid is high and stall is low.
// Config port: cfg_valid_i / cfg_ready_o, cfg_index_i selects the register,
// cfg_data_i is masked to the register width; ready is always high and
// writes are expected only while the pipeline is empty.
// From input transfer to output transfer a pixel passes one register stage
// each: unpack, weighted sum, divide by 255, dither and pack. Throughput is
// one pixel per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads the 16 bpp 5-6-5 layout, no blend.
module rgb_to_framebuffer_pixel (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rtfb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rtfb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       red_i,
  input  logic [7:0]                       green_i,
  input  logic [7:0]                       blue_i,
  input  logic [7:0]                       alpha_i,
  input  logic [31:0]                      dest_pixel_i,
  input  logic                             row_odd_i,
  input  logic                             column_odd_i,
  input  logic                             row_end_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [31:0]                      pixel_value_o,
  output logic                             last_in_row_o
);

  rtfb_pkg::cfg_t    cfg;
  rtfb_pkg::unpack_t unpack_data;
  rtfb_pkg::blend_t  blend_data;
  logic              unpack_valid, blend_valid;
  logic              advance;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;

  rtfb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rtfb_unpack u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .valid_i      (in_valid_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .alpha_i      (alpha_i),
    .dest_pixel_i (dest_pixel_i),
    .row_odd_i    (row_odd_i),
    .column_odd_i (column_odd_i),
    .row_end_i    (row_end_i),
    .cfg_i        (cfg),
    .valid_o      (unpack_valid),
    .data_o       (unpack_data)
  );

  rtfb_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (unpack_valid),
    .data_i  (unpack_data),
    .valid_o (blend_valid),
    .data_o  (blend_data)
  );

  rtfb_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (blend_valid),
    .data_i  (blend_data),
    .cfg_i   (cfg),
    .valid_o (out_valid_o),
    .pixel_o (pixel_value_o),
    .last_o  (last_in_row_o)
  );

`ifndef SYNTHESIS
  // input backpressure only comes from a waiting, stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // an accepted pixel reaches the output when every stage keeps advancing
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !in_stall_o ##1 !in_stall_o ##1 !in_stall_o
    |=> out_valid_o)
    else $error("accepted pixel did not reach the output");

  // a result leaves only through a transfer
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");
`endif

endmodule

FILE: tb/sv/pixel_scoreboard_pkg.sv
// scoreboard and packed-pixel predictor for the rgb to framebuffer pixel testbench
package pixel_scoreboard_pkg;
  import rtfb_pkg::*;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] dest;
    logic        row_odd;
    logic        column_odd;
    logic        row_end;
  } pixel_in_t;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } packed_pixel_t;

  class pixel_scoreboard;
    depth_e        depth;
    logic [3:0]    len [NUM_CH];
    logic [4:0]    off [NUM_CH];
    logic [1:0]    flags;
    packed_pixel_t expected_pixels [$];
    int unsigned   errors;

    function new();
      reset_regs();
      errors = 0;
    endfunction

    function void reset_regs();
      depth = DEPTH_16;
      len[CH_RED] = 4'd5;
      len[CH_GREEN] = 4'd6;
      len[CH_BLUE] = 4'd5;
      off[CH_RED] = 5'd11;
      off[CH_GREEN] = 5'd5;
      off[CH_BLUE] = 5'd0;
      flags = 2'd0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] data);
      case (idx)
        CFG_DEPTH_MODE:   depth = depth_e'(data[1:0]);
        CFG_RED_LENGTH:   len[CH_RED] = data[3:0];
        CFG_GREEN_LENGTH: len[CH_GREEN] = data[3:0];
        CFG_BLUE_LENGTH:  len[CH_BLUE] = data[3:0];
        CFG_RED_OFFSET:   off[CH_RED] = data[4:0];
        CFG_GREEN_OFFSET: off[CH_GREEN] = data[4:0];
        CFG_BLUE_OFFSET:  off[CH_BLUE] = data[4:0];
        CFG_MODE_FLAGS:   flags = data[1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] pack_pixel(pixel_in_t p);
      int unsigned chan [NUM_CH];
      int unsigned width [NUM_CH];
      int unsigned narrow, field, wide, dith, a;
      logic [31:0] mask, pix;
      chan[CH_RED] = 32'(p.red);
      chan[CH_GREEN] = 32'(p.green);
      chan[CH_BLUE] = 32'(p.blue);
      a = 32'(p.alpha);
      for (int c = 0; c < NUM_CH; c++) begin
        width[c] = (len[c] > LEN_MAX) ? 32'(LEN_MAX) : 32'(len[c]);
      end
      if (flags[FLAG_DIRECT]) begin
        narrow = width[CH_RED];
        if (width[CH_GREEN] < narrow) narrow = width[CH_GREEN];
        if (width[CH_BLUE] < narrow) narrow = width[CH_BLUE];
        for (int c = 0; c < NUM_CH; c++) width[c] = narrow;
      end
      case (depth)
        DEPTH_32: mask = MASK32;
        DEPTH_24: mask = MASK24;
        default:  mask = MASK16;
      endcase
      if (flags[FLAG_BLEND]) begin
        for (int c = 0; c < NUM_CH; c++) begin
          field = ((p.dest & mask) >> off[c]) & ((32'd1 << width[c]) - 32'd1);
          wide = (field << (8 - width[c])) & 32'hff;
          chan[c] = (wide * (255 - a) + chan[c] * a) / 255;
        end
      end
      if (depth == DEPTH_15 || depth == DEPTH_16) begin
        dith = (p.row_odd ? 32'd1 : 32'd3) ^ (p.column_odd ? 32'd3 : 32'd0);
        for (int c = 0; c < NUM_CH; c++) begin
          chan[c] += (c == CH_GREEN) ? dith : 2 * dith + 1;
          if (chan[c] > 255) chan[c] = 255;
        end
      end
      pix = '0;
      for (int c = 0; c < NUM_CH; c++) pix |= (chan[c] >> (8 - width[c])) << off[c];
      return pix & mask;
    endfunction

    function void note_input(pixel_in_t p);
      packed_pixel_t e;
      e.value = pack_pixel(p);
      e.last = p.row_end;
      expected_pixels.push_back(e);
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [31:0] value, logic last);
      packed_pixel_t e;
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel %h arrived with none pending", value));
        return;
      end
      e = expected_pixels.pop_front();
      if (value !== e.value) report($sformatf("pixel_value %h, predicted %h", value, e.value));
      if (last !== e.last) report($sformatf("last_in_row %b, predicted %b", last, e.last));
    endtask
  endclass

endpackage

FILE: tb/sv/rgb_to_framebuffer_pixel_tb.sv
// testbench top for rgb_to_framebuffer_pixel with directed and random pixel streams
module rgb_to_framebuffer_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtfb_pkg::*;
  import pixel_scoreboard_pkg::*;

  localparam int unsigned PIPE_LATENCY = 4;
  localparam int unsigned PHASE_ITEMS = 103;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [7:0] MODE_PLAIN = 8'd0;
  localparam logic [7:0] MODE_BLEND = 8'd1 << FLAG_BLEND;
  localparam logic [7:0] MODE_DIRECT = 8'd1 << FLAG_DIRECT;

  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            red_i = '0;
  logic [7:0]            green_i = '0;
  logic [7:0]            blue_i = '0;
  logic [7:0]            alpha_i = '0;
  logic [31:0]           dest_pixel_i = '0;
  logic                  row_odd_i = 1'b0;
  logic                  column_odd_i = 1'b0;
  logic                  row_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [31:0]           pixel_value_o;
  logic                  last_in_row_o;

  pixel_scoreboard pixel_sb = new();
  bit              hold_request = 1'b0;
  int unsigned     burst_left = 0;
  int unsigned     cycles = 0;

  rgb_to_framebuffer_pixel dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) pixel_sb.check_result(pixel_value_o, last_in_row_o);
  end

  initial begin : receiver
    int unsigned seg_len;
    stall_style_e style;
    @(posedge rst_ni);
    forever begin
      seg_len = $urandom_range(1, 60);
      style = stall_style_e'($urandom_range(0, 3));
      repeat (seg_len) begin
        @(negedge clk_i);
        if (hold_request) begin
          hold_request = 1'b0;
          repeat (HOLD_CYCLES) begin
            out_stall_i = 1'b1;
            @(negedge clk_i);
          end
        end
        case (style)
          STALL_NONE:  out_stall_i = 1'b0;
          STALL_LIGHT: out_stall_i = ($urandom_range(0, 4) == 0);
          STALL_HEAVY: out_stall_i = ($urandom_range(0, 3) != 0);
          default:     out_stall_i = ~out_stall_i;
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic write_reg(cfg_idx_e idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    pixel_sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_layout(logic [7:0] depth, logic [7:0] rl, logic [7:0] gl, logic [7:0] bl,
                            logic [7:0] ro, logic [7:0] go, logic [7:0] bo, logic [7:0] mode);
    write_reg(CFG_DEPTH_MODE, depth);
    write_reg(CFG_RED_LENGTH, rl);
    write_reg(CFG_GREEN_LENGTH, gl);
    write_reg(CFG_BLUE_LENGTH, bl);
    write_reg(CFG_RED_OFFSET, ro);
    write_reg(CFG_GREEN_OFFSET, go);
    write_reg(CFG_BLUE_OFFSET, bo);
    write_reg(CFG_MODE_FLAGS, mode);
  endtask

  task automatic send_pixel(pixel_in_t p);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    red_i = p.red;
    green_i = p.green;
    blue_i = p.blue;
    alpha_i = p.alpha;
    dest_pixel_i = p.dest;
    row_odd_i = p.row_odd;
    column_odd_i = p.column_odd;
    row_end_i = p.row_end;
    do @(posedge clk_i); while (in_stall_o);
    pixel_sb.note_input(p);
  endtask

  task automatic idle(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  task automatic paced_send(pixel_in_t p);
    if (burst_left == 0) begin
      idle(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_pixel(p);
  endtask

  task automatic drain();
    idle(1);
    while (pixel_sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  function automatic pixel_in_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] a, logic [31:0] dest,
                                           logic ro, logic co, logic re);
    pixel_in_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    p.dest = dest;
    p.row_odd = ro;
    p.column_odd = co;
    p.row_end = re;
    return p;
  endfunction

  function automatic logic [7:0] rand_level();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // rows of alternating columns with a row end, mixed with loose pixels
  task automatic run_phase(int unsigned n, bit with_hold);
    pixel_in_t p;
    int unsigned column;
    int unsigned row_len;
    bit row_parity;
    column = 0;
    row_len = 0;
    row_parity = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (with_hold && i == 20) hold_request = 1'b1;
      if (row_len == 0) begin
        row_len = $urandom_range(1, 12);
        column = 0;
        row_parity = ~row_parity;
      end
      p.red = rand_level();
      p.green = rand_level();
      p.blue = rand_level();
      p.alpha = rand_level();
      p.dest = ($urandom_range(0, 9) == 0) ? 32'hffff_ffff : $urandom;
      if ($urandom_range(0, 7) == 0) begin
        p.row_odd = 1'($urandom_range(0, 1));
        p.column_odd = 1'($urandom_range(0, 1));
        p.row_end = 1'($urandom_range(0, 1));
      end else begin
        p.row_odd = row_parity;
        p.column_odd = column[0];
        p.row_end = (row_len == 1);
        column++;
        row_len--;
      end
      paced_send(p);
    end
  endtask

  task automatic random_layout();
    logic [7:0] lens [NUM_CH];
    for (int c = 0; c < NUM_CH; c++) begin
      lens[c] = $urandom_range(0, 1) ? 8'($urandom)
                                     : 8'($urandom_range(1, 8) | ($urandom_range(0, 15) << 4));
    end
    set_layout(8'($urandom), lens[CH_RED], lens[CH_GREEN], lens[CH_BLUE],
               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin : stimulus
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset layout, all dither positions at zero, three at full scale, one mixed pixel
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 1'b0, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 1'b1, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 1'b0, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 1'b1, 1'b1));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 32'hffff_ffff, 1'b0, 1'b0, 1'b0));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 32'hffff_ffff, 1'b0, 1'b1, 1'b1));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 32'hffff_ffff, 1'b1, 1'b0, 1'b0));
    send_pixel(make_pixel(8'hfc, 8'h03, 8'h80, 8'h5a, 32'h1234_5678, 1'b1, 1'b1, 1'b1));
    drain();

    // blending: transparent, opaque, half, destination bits above the depth
    write_reg(CFG_MODE_FLAGS, MODE_BLEND);
    send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 8'h00, 32'hffff_ffff, 1'b0, 1'b0, 1'b0));
    send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 8'hff, 32'h0, 1'b0, 1'b1, 1'b0));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h80, 32'h0000_a5a5, 1'b1, 1'b0, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 32'hffff_0000, 1'b1, 1'b1, 1'b1));
    drain();

    // direct color takes the smallest length
    write_reg(CFG_MODE_FLAGS, MODE_BLEND | MODE_DIRECT);
    send_pixel(make_pixel(8'hff, 8'h07, 8'h80, 8'h40, 32'h0000_ffff, 1'b0, 1'b0, 1'b0));
    send_pixel(make_pixel(8'h13, 8'hf0, 8'h7f, 8'hc0, 32'h0000_8421, 1'b1, 1'b0, 1'b1));
    drain();

    // zero length, length above eight, overlapping fields, top offset
    set_layout(8'(DEPTH_32), 8'd0, 8'd15, 8'd9, 8'd31, 8'd4, 8'd0, MODE_BLEND);
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h00, 32'hffff_ffff, 1'b0, 1'b0, 1'b0));
    send_pixel(make_pixel(8'hff, 8'h5a, 8'hc3, 8'hff, 32'h0, 1'b0, 1'b1, 1'b0));
    send_pixel(make_pixel(8'h81, 8'h42, 8'h24, 8'd100, 32'h8765_4321, 1'b1, 1'b0, 1'b1));
    drain();

    set_layout(8'(DEPTH_15), 8'd5, 8'd5, 8'd5, 8'd10, 8'd5, 8'd0, MODE_PLAIN);
    run_phase(PHASE_ITEMS, 1'b0);
    drain();
    set_layout(8'(DEPTH_24), 8'd8, 8'd8, 8'd8, 8'd16, 8'd8, 8'd0, MODE_BLEND);
    run_phase(PHASE_ITEMS, 1'b1);
    drain();
    set_layout(8'(DEPTH_32), 8'd8, 8'd8, 8'd8, 8'd0, 8'd8, 8'd16, MODE_BLEND | MODE_DIRECT);
    run_phase(PHASE_ITEMS, 1'b0);
    drain();
    // upper data bits set, masked off by the register widths
    set_layout(8'hff, 8'hf0, 8'h0f, 8'h39, 8'hff, 8'he0, 8'h1e, 8'hfc | MODE_BLEND);
    run_phase(PHASE_ITEMS, 1'b0);
    drain();
    set_layout(8'hfc | 8'(DEPTH_16), 8'hf3, 8'd2, 8'd1, 8'd4, 8'd4, 8'd4,
               MODE_BLEND | MODE_DIRECT);
    run_phase(PHASE_ITEMS, 1'b1);
    drain();

    repeat (7) begin
      random_layout();
      run_phase(PHASE_ITEMS, $urandom_range(0, 3) == 0);
      drain();
    end

    if (pixel_sb.errors == 0 && pixel_sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
